@@ rtl/msbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared constants for the msb-first bitstream reader: sizes, widths,
// operation codes and status codes.
// ----------------------------------------------------------------------------
package msbr_pkg;

  localparam int BUFFER_BYTES  = 4096;
  localparam int MAX_READ_BITS = 32;
  localparam int BYTE_BITS     = 8;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int POS_W  = 13;
  // a read window spans at most this many bytes
  localparam int WIN_BYTES = (MAX_READ_BITS + 7 + 7) / BYTE_BITS;
  localparam int ACC_W     = WIN_BYTES * BYTE_BITS;
  localparam int NB_W      = 3;
  localparam int SH_W      = 6;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_SKIP  = 3'd2;
  localparam logic [2:0] OP_ALIGN = 3'd3;
  localparam logic [2:0] OP_SETP  = 3'd4;
  localparam logic [2:0] OP_SEEK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/msb_first_bitstream_reader.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader
// Byte buffer in a single-port synchronous memory with byte and bit cursors;
// writes bytes, reads up to 32 bits msb first, skips, aligns and seeks.
//
//   channel   handshake          fields
//   request   start / busy       op, bit_count, skip_amount, data_byte,
//                                target_position, seek_offset
//   result    done (one cycle)   bits_value, status, byte_position,
//                                bit_offset, used_size
//
// A read of n bytes (n = 1..5, set by bit offset plus bit count) is paced by
// the one memory port fetching one byte per cycle. Every other item gives its
// result the cycle after acceptance and busy stays low. Synchronous reset
// clears the cursors and the used size; the memory itself is not cleared.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader
  import msbr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          op,
  input  wire logic [5:0]          bit_count,
  input  wire logic [14:0]         skip_amount,
  input  wire logic [7:0]          data_byte,
  input  wire logic [POS_W-1:0]    target_position,
  input  wire logic signed [13:0]  seek_offset,
  output logic                     done,
  output logic [31:0]              bits_value,
  output logic [1:0]               status,
  output logic [POS_W-1:0]         byte_position,
  output logic [2:0]               bit_offset,
  output logic [POS_W-1:0]         used_size
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state;
  logic [POS_W-1:0]  cursor;
  logic [2:0]        cbit;
  logic [POS_W-1:0]  fill;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  logic [ADDR_W-1:0] rd_addr;
  logic [NB_W-1:0]   nb;
  logic [NB_W-1:0]   req_cnt;
  logic [NB_W-1:0]   got_cnt;
  logic              rvalid;
  logic [ACC_W-1:0]  acc;
  logic [2:0]        rd_bit;
  logic [5:0]        rd_cnt;

  logic              full;
  logic [16:0]       pos_bits;
  logic [16:0]       rd_end;
  logic              rd_ok;
  logic [16:0]       sk_end;
  logic              sk_ok;
  logic [POS_W:0]    al_byte;
  logic signed [14:0] fill_s;
  logic signed [14:0] aligned;
  logic signed [14:0] dest;
  logic              seek_ok;
  logic [5:0]        nb_sum;

  logic [5:0]        rd_sum;
  logic [SH_W-1:0]   sh;
  logic [ACC_W-1:0]  shifted;
  logic [32:0]       mask;

  // request checks
  always_comb begin
    full     = cursor >= POS_W'(BUFFER_BYTES);
    pos_bits = {1'b0, cursor, cbit};
    rd_end   = pos_bits + 17'(bit_count);
    rd_ok    = (bit_count <= 6'(MAX_READ_BITS)) && (cursor < fill) &&
               (rd_end <= {1'b0, fill, 3'b000});
    sk_end   = pos_bits + 17'(skip_amount);
    sk_ok    = sk_end[16:3] <= {1'b0, fill};
    al_byte  = {1'b0, cursor} + (POS_W+1)'(cbit != 3'd0);
    fill_s   = $signed({2'b00, fill});
    aligned  = $signed({1'b0, al_byte});
    dest     = aligned + 15'(seek_offset);
    seek_ok  = (aligned <= fill_s) && (dest >= 15'sd0) && (dest <= fill_s);
    nb_sum   = 6'(cbit) + bit_count + 6'd7;
  end

  // bit extraction from the fetched window
  always_comb begin
    rd_sum  = 6'(rd_bit) + rd_cnt;
    sh      = SH_W'({nb, 3'b000}) - rd_sum;
    shifted = acc >> sh;
    mask    = (33'd1 << rd_cnt) - 33'd1;
  end

  assign busy          = state != S_IDLE;
  assign byte_position = cursor;
  assign bit_offset    = cbit;
  assign used_size     = fill;

  assign mem_we   = (state == S_IDLE) && start && (op == OP_WRITE) && !full;
  assign mem_addr = (state == S_IDLE) ? cursor[ADDR_W-1:0] : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= data_byte;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cursor  <= '0;
      cbit    <= '0;
      fill    <= '0;
      done    <= 1'b0;
      rvalid  <= 1'b0;
      req_cnt <= '0;
      got_cnt <= '0;
    end else begin
      done   <= 1'b0;
      rvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            bits_value <= '0;
            status     <= ST_OK;
            done       <= 1'b1;
            case (op)
              OP_WRITE: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  cursor <= cursor + 1'b1;
                  if (cursor + 1'b1 > fill) begin
                    fill <= cursor + 1'b1;
                  end
                end
              end
              OP_READ: begin
                if (!rd_ok) begin
                  status <= ST_RANGE;
                end else if (bit_count != 6'd0) begin
                  done    <= 1'b0;
                  state   <= S_READ;
                  rd_bit  <= cbit;
                  rd_cnt  <= bit_count;
                  nb      <= nb_sum[5:3];
                  rd_addr <= cursor[ADDR_W-1:0];
                  req_cnt <= '0;
                  got_cnt <= '0;
                end
              end
              OP_SKIP: begin
                if (!sk_ok) begin
                  status <= ST_RANGE;
                end else begin
                  cursor <= sk_end[POS_W+2:3];
                  cbit   <= sk_end[2:0];
                end
              end
              OP_ALIGN: begin
                if (cbit != 3'd0) begin
                  if (al_byte > {1'b0, fill}) begin
                    status <= ST_RANGE;
                  end else begin
                    cursor <= al_byte[POS_W-1:0];
                    cbit   <= '0;
                  end
                end
              end
              OP_SETP: begin
                if (target_position > fill) begin
                  status <= ST_RANGE;
                end else begin
                  cursor <= target_position;
                  cbit   <= '0;
                end
              end
              OP_SEEK: begin
                if (!seek_ok) begin
                  status <= ST_RANGE;
                end else begin
                  cursor <= dest[POS_W-1:0];
                  cbit   <= '0;
                end
              end
              default: begin
                status <= ST_RANGE;
              end
            endcase
          end
        end
        S_READ: begin
          if (req_cnt != nb) begin
            req_cnt <= req_cnt + 1'b1;
            rd_addr <= rd_addr + 1'b1;
          end
          rvalid <= req_cnt != nb;
          if (rvalid) begin
            acc     <= {acc[ACC_W-9:0], rdata};
            got_cnt <= got_cnt + 1'b1;
            if (got_cnt + 1'b1 == nb) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          bits_value <= shifted[31:0] & mask[31:0];
          cursor     <= cursor + POS_W'(rd_sum[5:3]);
          cbit       <= rd_sum[2:0];
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_fill: assert property (@(posedge clk) disable iff (rst)
    byte_position <= used_size)
    else $error("byte cursor beyond used size");

  a_fill_in_buffer: assert property (@(posedge clk) disable iff (rst)
    used_size <= POS_W'(BUFFER_BYTES))
    else $error("used size beyond buffer");

  a_item_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither finished nor in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");
`endif

endmodule
`default_nettype wire

@@ tb/sv/msb_first_bitstream_reader_tb.sv @@
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_tb
// Self-checking bench for the msb-first bitstream reader. A clocked driver
// sends queued requests in bursts with random gaps, and a clocked monitor
// works out each accepted request's cursor report with a local model of the
// buffer and cursors. It then compares every reported field. Stimulus runs a
// short directed opening, then random sequences that grow the buffer, rewind
// and read back, and finally probes the top end of the used bytes.
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_tb;
  import msbr_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [2:0]        op;
    logic [5:0]        count;
    logic [14:0]       skip;
    logic [7:0]        data;
    logic [POS_W-1:0]  target;
    logic signed [13:0] seek;
    int                gap;
  } reader_req_t;

  typedef struct {
    logic [31:0]      value;
    logic [1:0]       status;
    logic [POS_W-1:0] pos;
    logic [2:0]       off;
    logic [POS_W-1:0] used;
  } reader_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] op = '0;
  logic [5:0] bit_count = '0;
  logic [14:0] skip_amount = '0;
  logic [7:0] data_byte = '0;
  logic [POS_W-1:0] target_position = '0;
  logic signed [13:0] seek_offset = '0;
  logic done;
  logic [31:0] bits_value;
  logic [1:0] status;
  logic [POS_W-1:0] byte_position;
  logic [2:0] bit_offset;
  logic [POS_W-1:0] used_size;

  msb_first_bitstream_reader DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the buffer and cursors
  logic [7:0] model_mem [BUFFER_BYTES];
  int model_byte = 0;
  int model_bit = 0;
  int model_fill = 0;

  reader_req_t bit_requests[$];
  reader_rsp_t cursor_reports[$];
  int burst_left = 0;
  int plan_fill = 0;
  int total_items = 0;
  int accepted_n = 0;
  int results_n = 0;
  int fail_count = 0;
  int cycles = 0;
  int op_seen [8];
  int status_seen [4];
  logic taken = 1'b0;
  logic have_next = 1'b0;
  int idle_left = 0;
  reader_req_t next_req;

  function automatic reader_rsp_t advance_cursor_model(reader_req_t rq);
    reader_rsp_t rs;
    int first, last, aligned, dest, soff, b;
    rs.value = '0;
    rs.status = ST_OK;
    first = model_byte * BYTE_BITS + model_bit;
    case (rq.op)
      OP_WRITE: begin
        if (model_byte >= BUFFER_BYTES) begin
          rs.status = ST_FULL;
        end else begin
          model_mem[model_byte] = rq.data;
          model_byte++;
          if (model_byte > model_fill) model_fill = model_byte;
        end
      end
      OP_READ: begin
        last = first + int'(rq.count);
        if (int'(rq.count) > MAX_READ_BITS || model_byte >= model_fill ||
            last > model_fill * BYTE_BITS) begin
          rs.status = ST_RANGE;
        end else begin
          for (b = first; b < last; b++)
            rs.value = {rs.value[30:0], model_mem[b / BYTE_BITS][7 - b % BYTE_BITS]};
          model_byte = last / BYTE_BITS;
          model_bit = last % BYTE_BITS;
        end
      end
      OP_SKIP: begin
        last = first + int'(rq.skip);
        if (last / BYTE_BITS > model_fill) begin
          rs.status = ST_RANGE;
        end else begin
          model_byte = last / BYTE_BITS;
          model_bit = last % BYTE_BITS;
        end
      end
      OP_ALIGN: begin
        if (model_bit != 0) begin
          if (model_byte + 1 > model_fill) begin
            rs.status = ST_RANGE;
          end else begin
            model_byte++;
            model_bit = 0;
          end
        end
      end
      OP_SETP: begin
        if (int'(rq.target) > model_fill) begin
          rs.status = ST_RANGE;
        end else begin
          model_byte = int'(rq.target);
          model_bit = 0;
        end
      end
      OP_SEEK: begin
        soff = rq.seek;
        aligned = (model_bit != 0) ? model_byte + 1 : model_byte;
        dest = aligned + soff;
        if (aligned > model_fill || dest < 0 || dest > model_fill) begin
          rs.status = ST_RANGE;
        end else begin
          model_byte = dest;
          model_bit = 0;
        end
      end
      default: rs.status = ST_RANGE;
    endcase
    rs.pos = POS_W'(model_byte);
    rs.off = 3'(model_bit);
    rs.used = POS_W'(model_fill);
    return rs;
  endfunction

  // queue one item; fields it does not use carry random values
  task automatic push_op(logic [2:0] code, int arg);
    reader_req_t rq;
    rq.op = code;
    rq.count = 6'($urandom);
    rq.skip = 15'($urandom);
    rq.data = 8'($urandom);
    rq.target = POS_W'($urandom);
    rq.seek = 14'($urandom);
    case (code)
      OP_WRITE: rq.data = 8'(arg);
      OP_READ:  rq.count = 6'(arg);
      OP_SKIP:  rq.skip = 15'(arg);
      OP_SETP:  rq.target = POS_W'(arg);
      OP_SEEK:  rq.seek = 14'(arg);
      default: ;
    endcase
    if (burst_left == 0) begin
      rq.gap = $urandom_range(1, 9);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end else begin
      rq.gap = 0;
      burst_left--;
    end
    bit_requests.push_back(rq);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s is %0h, should be %0h", results_n, what, got, want);
    fail_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (!have_next && bit_requests.size() > 0) begin
        next_req = bit_requests.pop_front();
        have_next = 1'b1;
        idle_left = next_req.gap;
      end
      if (have_next && idle_left == 0) begin
        op <= next_req.op;
        bit_count <= next_req.count;
        skip_amount <= next_req.skip;
        data_byte <= next_req.data;
        target_position <= next_req.target;
        seek_offset <= next_req.seek;
        start <= 1'b1;
        have_next = 1'b0;
      end else begin
        start <= 1'b0;
        if (idle_left > 0) idle_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    reader_req_t seen;
    reader_rsp_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("msb_first_bitstream_reader verification failed");
      $finish;
    end else if (!rst) begin
      if (done === 1'b1) begin
        if (cursor_reports.size() == 0) begin
          report_mismatch("unrequested result, status", 32'(status), 32'(ST_OK));
        end else begin
          want = cursor_reports.pop_front();
          if (bits_value !== want.value) report_mismatch("bits_value", bits_value, want.value);
          if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
          if (byte_position !== want.pos)
            report_mismatch("byte_position", 32'(byte_position), 32'(want.pos));
          if (bit_offset !== want.off)
            report_mismatch("bit_offset", 32'(bit_offset), 32'(want.off));
          if (used_size !== want.used)
            report_mismatch("used_size", 32'(used_size), 32'(want.used));
          if (!$isunknown(status)) status_seen[status]++;
        end
        results_n++;
      end
      if (start && !busy) begin
        seen.op = op;
        seen.count = bit_count;
        seen.skip = skip_amount;
        seen.data = data_byte;
        seen.target = target_position;
        seen.seek = seek_offset;
        seen.gap = 0;
        cursor_reports.push_back(advance_cursor_model(seen));
        op_seen[op]++;
        accepted_n++;
      end
    end
    taken <= !rst && start && !busy;
  end

  initial begin
    int r, n, k;
    // empty buffer, then a small known pattern
    push_op(OP_READ, 0);
    push_op(OP_ALIGN, 0);
    push_op(OP_SEEK, 0);
    push_op(OP_SKIP, 8);
    push_op(OP_WRITE, 'hFF);
    push_op(OP_WRITE, 'h00);
    push_op(OP_WRITE, 'hA5);
    push_op(OP_WRITE, 'h5A);
    push_op(OP_WRITE, 'h81);
    push_op(OP_SETP, 0);
    push_op(OP_READ, 3);
    push_op(OP_READ, 32);
    push_op(OP_READ, 5);
    push_op(OP_READ, 0);
    push_op(OP_SETP, 6);
    push_op(OP_SEEK, -5);
    push_op(OP_SKIP, 7);
    push_op(OP_SEEK, 3);
    push_op(OP_SKIP, 4);
    push_op(OP_ALIGN, 0);
    push_op(OP_READ, 33);
    push_op(OP_SKIP, 32767);
    push_op(OP_SETP, 8191);
    push_op(OP_SEEK, -8192);
    push_op(OP_SPARE6, 0);
    push_op(OP_SPARE7, 0);
    plan_fill = 5;

    while (bit_requests.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // append at the end of the used bytes
        push_op(OP_SETP, plan_fill);
        n = $urandom_range(1, 12);
        repeat (n) push_op(OP_WRITE, $urandom_range(0, 255));
        plan_fill = (plan_fill + n > BUFFER_BYTES) ? BUFFER_BYTES : plan_fill + n;
      end else if (r < 60) begin
        // rewind and read back
        push_op(OP_SETP, $urandom_range(0, plan_fill));
        k = $urandom_range(1, 6);
        repeat (k) begin
          n = $urandom_range(0, 9);
          if (n < 7) push_op(OP_READ, $urandom_range(0, MAX_READ_BITS));
          else if (n < 8) push_op(OP_SKIP, $urandom_range(0, 20));
          else push_op(OP_ALIGN, 0);
        end
      end else if (r < 72) begin
        push_op(OP_SEEK, $urandom_range(0, 32) - 16);
        repeat ($urandom_range(1, 3)) push_op(OP_READ, $urandom_range(0, MAX_READ_BITS));
      end else if (r < 80) begin
        push_op(OP_SKIP, $urandom_range(0, 64));
        push_op(OP_READ, $urandom_range(0, MAX_READ_BITS));
      end else if (r < 86) begin
        // overwrite from a point within the used bytes; writes may run past their end
        push_op(OP_SETP, $urandom_range(0, plan_fill));
        repeat ($urandom_range(1, 3)) push_op(OP_WRITE, $urandom_range(0, 255));
      end else if (r < 92) begin
        push_op(OP_ALIGN, 0);
        push_op(OP_READ, $urandom_range(0, MAX_READ_BITS));
      end else begin
        push_op(3'($urandom_range(0, 7)), int'($urandom));
      end
    end

    // make sure there is room below the top end, then work there
    while (plan_fill < 64) begin
      push_op(OP_SETP, plan_fill);
      repeat (8) push_op(OP_WRITE, $urandom_range(0, 255));
      plan_fill += 8;
    end
    push_op(OP_SETP, plan_fill);
    push_op(OP_READ, 0);
    push_op(OP_SKIP, 0);
    push_op(OP_SKIP, 1);
    push_op(OP_SEEK, 1);
    push_op(OP_SEEK, -plan_fill);
    push_op(OP_SEEK, plan_fill);
    push_op(OP_SEEK, -plan_fill - 1);
    push_op(OP_SETP, plan_fill - 1);
    push_op(OP_READ, 8);
    push_op(OP_SETP, plan_fill - 4);
    push_op(OP_READ, 32);
    push_op(OP_SETP, plan_fill - 4);
    push_op(OP_SKIP, 1);
    push_op(OP_READ, 32);
    push_op(OP_READ, 31);
    push_op(OP_SETP, 0);
    push_op(OP_SKIP, 32767);
    push_op(OP_ALIGN, 0);
    push_op(OP_SEEK, -1);
    push_op(OP_SKIP, 7);
    push_op(OP_READ, 1);
    repeat (40) begin
      r = $urandom_range(0, 3);
      if (r == 0) push_op(OP_SETP, $urandom_range(plan_fill - 40, plan_fill));
      else if (r == 1) push_op(OP_SKIP, $urandom_range(0, 40));
      else push_op(OP_READ, $urandom_range(0, MAX_READ_BITS));
    end
    total_items = bit_requests.size();

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (accepted_n < total_items || cursor_reports.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d items: %0d writes, %0d reads, %0d skips, %0d aligns, %0d sets,",
             accepted_n, op_seen[OP_WRITE], op_seen[OP_READ], op_seen[OP_SKIP],
             op_seen[OP_ALIGN], op_seen[OP_SETP]);
    $display("  %0d seeks, %0d spare",
             op_seen[OP_SEEK], op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
    $display("%0d results: %0d ok, %0d out of range, %0d buffer full, %0d mismatches",
             results_n, status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
             fail_count);
    if (fail_count == 0) begin
      $display("msb_first_bitstream_reader verification clean");
    end else begin
      $display("msb_first_bitstream_reader verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/msbr_pkg.sv
rtl/msb_first_bitstream_reader.sv
tb/sv/msb_first_bitstream_reader_tb.sv
